@@ rtl/hss_pkg.sv @@
// Shared constants and control/status types for the histogram split search.
// No dependencies; used by hss_score_unit and histogram_stump_split_search_top.
package hss_pkg;

   // Default sizes
   localparam int MAX_BINS_DEF    = 256;
   localparam int WEIGHT_BITS_DEF = 32;

   // Accumulator headroom over the weight width
   localparam int ACC_EXTRA = 8;

   // Fixed field widths of the result channel
   localparam int FEATURE_BITS   = 10;
   localparam int BIN_OUT_BITS   = 8;
   localparam int SCORE_OUT_BITS = 41;

   // Control into the score unit
   typedef struct packed {
      logic valid;   // left prefix sum presented this cycle
      logic clear;   // start a new search
   } hss_ctl_type;

   // Status out of the score unit
   typedef struct packed {
      logic busy;      // a split is still in the compare stage
      logic found;     // at least one split evaluated
      logic polarity;  // best split has the heavier left side
   } hss_stat_type;

endpackage

@@ rtl/hss_score_unit.sv @@
// Shared split scoring and best-split tracking for the histogram split search.
// Depends on hss_pkg for control/status types and the feature width.
module hss_score_unit #(
   parameter int ACC_BITS = hss_pkg::WEIGHT_BITS_DEF + hss_pkg::ACC_EXTRA,
   parameter int IDX_BITS = $clog2(hss_pkg::MAX_BINS_DEF)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hss_pkg::hss_ctl_type             ctl,
   input  logic [IDX_BITS-1:0]              split_bin,
   input  logic [ACC_BITS-1:0]              left_sum,
   input  logic [ACC_BITS-1:0]              total_sum,
   input  logic [hss_pkg::FEATURE_BITS-1:0] feature,
   output hss_pkg::hss_stat_type            stat,
   output logic [hss_pkg::FEATURE_BITS-1:0] top_feature,
   output logic [IDX_BITS-1:0]              top_bin,
   output logic [ACC_BITS:0]                top_score
);

   localparam int DW = ACC_BITS + 2;   // signed difference width
   localparam int SW = ACC_BITS + 1;   // magnitude width

   logic [DW-1:0]       left_ext;
   logic [DW-1:0]       total_ext;
   logic [DW-1:0]       dbl_left;
   logic [DW-1:0]       dpos_in;
   logic [DW-1:0]       dneg_in;

   logic                v1_ff;
   logic [IDX_BITS-1:0] j1_ff;
   logic [DW-1:0]       dpos_ff;
   logic [DW-1:0]       dneg_ff;

   logic                neg;
   logic [SW-1:0]       mag;
   logic                pol;
   logic                take;

   logic                found_ff;
   logic                pol_ff;
   logic [SW-1:0]       score_ff;
   logic [hss_pkg::FEATURE_BITS-1:0] feature_ff;
   logic [IDX_BITS-1:0] bin_ff;

   // Stage 1: 2*left - total and its negation, side by side
   assign left_ext  = {{2{left_sum[ACC_BITS-1]}}, left_sum};
   assign total_ext = {{2{total_sum[ACC_BITS-1]}}, total_sum};
   assign dbl_left  = {left_ext[DW-2:0], 1'b0};
   assign dpos_in   = dbl_left - total_ext;
   assign dneg_in   = total_ext - dbl_left;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.valid;
      end
      j1_ff   <= split_bin;
      dpos_ff <= dpos_in;
      dneg_ff <= dneg_in;
   end

   // Stage 2: pick the magnitude and compare against the best so far
   assign neg  = dpos_ff[DW-1];
   assign mag  = neg ? dneg_ff[SW-1:0] : dpos_ff[SW-1:0];
   assign pol  = !neg && (dpos_ff != '0);
   assign take = v1_ff && (!found_ff || (mag > score_ff));

   always_ff @(posedge clock) begin
      priority if (reset || ctl.clear) begin
         found_ff   <= 1'b0;
         pol_ff     <= 1'b0;
         score_ff   <= '0;
         feature_ff <= '0;
         bin_ff     <= '0;
      end else if (take) begin
         found_ff   <= 1'b1;
         pol_ff     <= pol;
         score_ff   <= mag;
         feature_ff <= feature;
         bin_ff     <= j1_ff;
      end
   end

   assign stat.busy     = v1_ff;
   assign stat.found    = found_ff;
   assign stat.polarity = pol_ff;
   assign top_feature   = feature_ff;
   assign top_bin       = bin_ff;
   assign top_score     = score_ff;

endmodule

@@ rtl/histogram_stump_split_search_top.sv @@
// Top level of the histogram decision-stump split search.
// Depends on hss_pkg and hss_score_unit.
//
//  channel  direction  handshake           payload
//  req_     in         req_valid/ready     bin weight, feature id, usable, last bin/feature
//  rsp_     out        rsp_valid/ready     found, best feature/bin, polarity, score, overflow
//
// A bin that is not the last of its feature leaves the block idle for the next bin.
// After the last bin of a usable feature, the prefix store's single read port
// feeds the shared score unit one split per cycle, then two pipeline stages
// drain. The result is loaded after the final feature, once the channel is free.
// Reset clears counters, the search state and the sequencer; the prefix store is
// not cleared. req_ready is high only while idle; a pending result does not block
// new bins, but the next result waits until the pending one is transferred.
module histogram_stump_split_search_top #(
   parameter int MAX_BINS    = hss_pkg::MAX_BINS_DEF,
   parameter int WEIGHT_BITS = hss_pkg::WEIGHT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [WEIGHT_BITS-1:0]             req_bin_weight,
   input  logic [hss_pkg::FEATURE_BITS-1:0]   req_feature_id,
   input  logic                               req_feature_usable,
   input  logic                               req_last_bin,
   input  logic                               req_last_feature,
   input  logic                               req_valid,
   output logic                               req_ready,
   output logic                               rsp_found,
   output logic [hss_pkg::FEATURE_BITS-1:0]   rsp_best_feature,
   output logic [hss_pkg::BIN_OUT_BITS-1:0]   rsp_best_bin,
   output logic                               rsp_left_heavier,
   output logic [hss_pkg::SCORE_OUT_BITS-1:0] rsp_best_score,
   output logic                               rsp_bin_overflow,
   output logic                               rsp_valid,
   input  logic                               rsp_ready
);

   localparam int ACC_BITS = WEIGHT_BITS + hss_pkg::ACC_EXTRA;
   localparam int AW       = $clog2(MAX_BINS);
   localparam int CW       = $clog2(MAX_BINS + 1);
   localparam int SW       = ACC_BITS + 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [ACC_BITS-1:0] total_ff, total_in;
   logic [ACC_BITS-1:0] sum_next;
   logic                overflow_ff, overflow_in;
   logic [hss_pkg::FEATURE_BITS-1:0] fid_ff, fid_in;
   logic                lastf_ff, lastf_in;
   logic [AW-1:0]       ra_ff, ra_in;

   logic                accept;
   logic                room;
   logic                wr_en;
   logic [CW-1:0]       count_acc;
   logic                last_issue;
   logic                load_rsp;

   logic [ACC_BITS-1:0] mem [MAX_BINS];
   logic [ACC_BITS-1:0] rd_ff;
   logic                v0_ff;
   logic [AW-1:0]       j0_ff;

   hss_pkg::hss_ctl_type  ctl;
   hss_pkg::hss_stat_type stat;
   logic [hss_pkg::FEATURE_BITS-1:0] top_feature;
   logic [AW-1:0]       top_bin;
   logic [SW-1:0]       top_score;
   logic [SW+hss_pkg::SCORE_OUT_BITS-1:0] score_wide;
   logic [AW+hss_pkg::BIN_OUT_BITS-1:0]   bin_wide;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign room      = (count_ff < CW'(MAX_BINS));
   assign wr_en     = accept && room;
   assign sum_next  = total_ff + {{hss_pkg::ACC_EXTRA{req_bin_weight[WEIGHT_BITS-1]}},
                                  req_bin_weight};
   assign count_acc = room ? count_ff + CW'(1) : count_ff;
   assign last_issue = (CW'(ra_ff) + CW'(2)) == count_ff;
   assign load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid || rsp_ready);

   // Sequencer: load bins, walk splits, drain the score pipe, post the result
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      total_in    = total_ff;
      overflow_in = overflow_ff;
      fid_in      = fid_ff;
      lastf_in    = lastf_ff;
      ra_in       = ra_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (room) begin
                  total_in = sum_next;
               end else begin
                  overflow_in = 1'b1;
               end
               count_in = count_acc;
               if (req_last_bin) begin
                  fid_in   = req_feature_id;
                  lastf_in = req_last_feature;
                  ra_in    = '0;
                  if (req_feature_usable && (count_acc >= CW'(2))) begin
                     if (room) begin
                        total_in = sum_next;
                     end
                     state_in = ST_WALK;
                  end else begin
                     count_in = '0;
                     total_in = '0;
                     state_in = req_last_feature ? ST_FINISH : ST_IDLE;
                  end
               end
            end
         end
         ST_WALK: begin
            ra_in = ra_ff + AW'(1);
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v0_ff && !stat.busy) begin
               count_in = '0;
               total_in = '0;
               state_in = lastf_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (load_rsp) begin
               overflow_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         total_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         total_ff    <= total_in;
         overflow_ff <= overflow_in;
      end
      fid_ff   <= fid_in;
      lastf_ff <= lastf_in;
      ra_ff    <= ra_in;
   end

   // Prefix store: written while loading, read one split per cycle during the walk
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= sum_next;
      end
      rd_ff <= mem[ra_ff];
      j0_ff <= ra_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= (state_ff == ST_WALK);
      end
   end

   // Shared score and compare unit
   assign ctl.valid = v0_ff;
   assign ctl.clear = load_rsp;

   hss_score_unit #(
      .ACC_BITS (ACC_BITS),
      .IDX_BITS (AW)
   ) u_score (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .split_bin   (j0_ff),
      .left_sum    (rd_ff),
      .total_sum   (total_ff),
      .feature     (fid_ff),
      .stat        (stat),
      .top_feature (top_feature),
      .top_bin     (top_bin),
      .top_score   (top_score)
   );

   // Result register; fit score and bin to the channel widths
   assign score_wide = {{hss_pkg::SCORE_OUT_BITS{1'b0}}, top_score};
   assign bin_wide   = {{hss_pkg::BIN_OUT_BITS{1'b0}}, top_bin};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
      if (load_rsp) begin
         rsp_found        <= stat.found;
         rsp_best_feature <= top_feature;
         rsp_best_bin     <= bin_wide[hss_pkg::BIN_OUT_BITS-1:0];
         rsp_left_heavier <= stat.polarity;
         rsp_best_score   <= score_wide[hss_pkg::SCORE_OUT_BITS-1:0];
         rsp_bin_overflow <= overflow_ff;
      end
   end

endmodule

@@ dv/hss_tb_pkg.sv @@
`timescale 1ns / 1ps
// Testbench types and the split-search scoreboard for the histogram stump block.
// Depends on hss_pkg; compile after it and before tb_top.
package hss_tb_pkg;
   import hss_pkg::*;

   localparam int BIN_LIMIT    = MAX_BINS_DEF;
   localparam int WGT_W        = WEIGHT_BITS_DEF;
   localparam int ACC_W        = WEIGHT_BITS_DEF + ACC_EXTRA;
   localparam int REPORT_LIMIT = 10;

   // One bin transfer on the request side
   typedef struct packed {
      logic [WGT_W-1:0]        weight;
      logic [FEATURE_BITS-1:0] feature_id;
      logic                    usable;
      logic                    last_bin;
      logic                    last_feature;
   } hist_bin_type;

   // One search result on the response side
   typedef struct packed {
      logic                      found;
      logic [FEATURE_BITS-1:0]   feature;
      logic [BIN_OUT_BITS-1:0]   split_bin;
      logic                      left_heavier;
      logic [SCORE_OUT_BITS-1:0] score;
      logic                      overflow;
   } split_result_type;

   class stump_split_scoreboard;
      // prefix sums of the feature being loaded
      logic signed [ACC_W-1:0] prefix_sums [BIN_LIMIT];
      int unsigned             stored_bins;
      logic signed [ACC_W-1:0] feature_total;
      // best split of the current search
      longint unsigned         lead_score;
      logic [FEATURE_BITS-1:0] lead_feature;
      logic [BIN_OUT_BITS-1:0] lead_bin;
      bit                      lead_left_heavier;
      bit                      split_seen;
      bit                      overflow_hit;

      split_result_type expected_splits [$];
      int unsigned      failures;
      int unsigned      results_seen;
      int unsigned      found_seen;
      int unsigned      overflow_results;

      function new();
         stored_bins      = 0;
         feature_total    = '0;
         failures         = 0;
         results_seen     = 0;
         found_seen       = 0;
         overflow_results = 0;
         clear_search();
      endfunction

      function void clear_search();
         lead_score        = 0;
         lead_feature      = '0;
         lead_bin          = '0;
         lead_left_heavier = 1'b0;
         split_seen        = 1'b0;
         overflow_hit      = 1'b0;
      endfunction

      function int pending();
         return expected_splits.size();
      endfunction

      function string show(split_result_type r);
         return $sformatf("found=%0b feature=%0d bin=%0d left_heavier=%0b score=%0d overflow=%0b",
                          r.found, r.feature, r.split_bin, r.left_heavier, r.score, r.overflow);
      endfunction

      function void report(string what, string detail);
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("[%0t] %s: %s", $time, what, detail);
      endfunction

      // Walk splits 1..n-1; only a strictly larger score replaces the lead
      function void scan_splits(logic [FEATURE_BITS-1:0] fid);
         longint signed   tot;
         longint signed   left;
         longint signed   diff;
         longint unsigned mag;
         tot = feature_total;
         for (int unsigned j = 1; j < stored_bins; j++) begin
            left = prefix_sums[j-1];
            diff = 2 * left - tot;
            mag  = (diff < 0) ? -diff : diff;
            if (!split_seen || mag > lead_score) begin
               split_seen        = 1'b1;
               lead_score        = mag;
               lead_feature      = fid;
               lead_bin          = j[BIN_OUT_BITS-1:0];
               lead_left_heavier = (diff > 0);
            end
         end
      endfunction

      // Accepted bin: update sums, close the feature / search when marked
      function void note_bin(hist_bin_type b);
         logic signed [WGT_W-1:0] w;
         longint signed           sum;
         split_result_type        r;
         w = b.weight;
         if (stored_bins < BIN_LIMIT) begin
            sum                      = longint'(feature_total) + longint'(w);
            feature_total            = sum[ACC_W-1:0];
            prefix_sums[stored_bins] = feature_total;
            stored_bins++;
         end else begin
            // bins past the store depth are dropped
            overflow_hit = 1'b1;
         end
         if (!b.last_bin)
            return;
         if (b.usable)
            scan_splits(b.feature_id);
         stored_bins   = 0;
         feature_total = '0;
         if (!b.last_feature)
            return;
         r.found        = split_seen;
         r.feature      = lead_feature;
         r.split_bin    = lead_bin;
         r.left_heavier = lead_left_heavier;
         r.score        = lead_score[SCORE_OUT_BITS-1:0];
         r.overflow     = overflow_hit;
         expected_splits.insert(expected_splits.size(), r);
         clear_search();
      endfunction

      // Accepted result: compare against the oldest expected search outcome
      function void check_result(split_result_type got);
         split_result_type want;
         bit               bad;
         results_seen++;
         if (got.found === 1'b1)
            found_seen++;
         if (got.overflow === 1'b1)
            overflow_results++;
         if (expected_splits.size() == 0) begin
            report("unexpected result", show(got));
            return;
         end
         want = expected_splits.pop_front();
         bad  = got.found !== want.found || got.feature !== want.feature ||
                got.split_bin !== want.split_bin || got.left_heavier !== want.left_heavier ||
                got.score !== want.score || got.overflow !== want.overflow;
         if (bad)
            report("result mismatch", {"expected ", show(want), " | actual ", show(got)});
      endfunction

      // Anything still queued at the end never came out
      function void close_out();
         while (expected_splits.size() > 0)
            report("missing result", show(expected_splits.pop_front()));
      endfunction
   endclass

endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for histogram_stump_split_search_top: clock, reset, stimulus and handshakes.
// Depends on hss_pkg, hss_tb_pkg and the RTL top level.
module tb_top;
   import hss_pkg::*;
   import hss_tb_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 10;
   localparam int BIN_TARGET   = 1850;
   localparam int HOLD_AFTER   = 600;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = BIN_LIMIT + 16;
   localparam int LIMIT_CYCLES = 800_000;

   localparam logic [WGT_W-1:0] W_MAX = {1'b0, {(WGT_W-1){1'b1}}};
   localparam logic [WGT_W-1:0] W_MIN = {1'b1, {(WGT_W-1){1'b0}}};

   typedef enum int {WGT_FULL, WGT_SMALL, WGT_EXTREME, WGT_ZERO} wgt_mode_type;

   logic                      clock              = 1'b0;
   logic                      reset              = 1'b1;
   logic [WGT_W-1:0]          req_bin_weight     = '0;
   logic [FEATURE_BITS-1:0]   req_feature_id     = '0;
   logic                      req_feature_usable = 1'b0;
   logic                      req_last_bin       = 1'b0;
   logic                      req_last_feature   = 1'b0;
   logic                      req_valid          = 1'b0;
   logic                      req_ready;
   logic                      rsp_found;
   logic [FEATURE_BITS-1:0]   rsp_best_feature;
   logic [BIN_OUT_BITS-1:0]   rsp_best_bin;
   logic                      rsp_left_heavier;
   logic [SCORE_OUT_BITS-1:0] rsp_best_score;
   logic                      rsp_bin_overflow;
   logic                      rsp_valid;
   logic                      rsp_ready          = 1'b0;

   logic                      rsp_hold           = 1'b0;
   bit                        reset_done         = 1'b0;
   int unsigned               bins_sent          = 0;
   int unsigned               stalled_cycles     = 0;

   stump_split_scoreboard split_board;
   hist_bin_type          bin_stream [$];

   histogram_stump_split_search_top DUT (.*);

   always #(CLK_PERIOD/2) clock = ~clock;

   // Idle length: mostly none or short, a few long, with calm stretches of none
   function automatic int unsigned pick_gap(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [WGT_W-1:0] pick_weight(wgt_mode_type m);
      int s;
      case (m)
         WGT_FULL: return $urandom;
         WGT_SMALL: begin
            s = int'($urandom_range(0, 512)) - 256;
            return s;
         end
         WGT_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return W_MAX;
               1:       return W_MIN;
               2:       return '1;
               default: return 32'h0001_0000;   // 1.0
            endcase
         end
         default: return '0;
      endcase
   endfunction

   function automatic void push_bin(logic [WGT_W-1:0] w, logic [FEATURE_BITS-1:0] fid,
                                    logic usable, logic lastb, logic lastf);
      hist_bin_type b;
      b.weight       = w;
      b.feature_id   = fid;
      b.usable       = usable;
      b.last_bin     = lastb;
      b.last_feature = lastf;
      bin_stream.insert(bin_stream.size(), b);
   endfunction

   // Non-final bins carry junk id/usable and a stray last_feature now and then
   function automatic void add_feature(int unsigned n, wgt_mode_type m,
                                       logic [FEATURE_BITS-1:0] fid, logic usable,
                                       logic lastf);
      for (int unsigned i = 1; i <= n; i++) begin
         if (i < n)
            push_bin(pick_weight(m), FEATURE_BITS'($urandom), 1'($urandom), 1'b0,
                     $urandom_range(0, 7) == 0);
         else
            push_bin(pick_weight(m), fid, usable, 1'b1, lastf);
      end
   endfunction

   // Well-formed search: a few mostly short features, the last one closes it
   function automatic void add_search();
      int unsigned nfeat;
      int unsigned nb;
      nfeat = $urandom_range(1, 5);
      for (int unsigned f = 0; f < nfeat; f++) begin
         case ($urandom_range(0, 19))
            0, 1:    nb = 1;
            2:       nb = $urandom_range(20, 64);
            default: nb = $urandom_range(2, 10);
         endcase
         add_feature(nb, wgt_mode_type'($urandom_range(0, 3)), FEATURE_BITS'($urandom),
                     $urandom_range(0, 4) != 0, f == nfeat - 1);
      end
   endfunction

   // Offer each bin, hold it until the transfer, then note it
   task automatic send_bins();
      int unsigned  gap;
      int unsigned  tx_calm;
      hist_bin_type b;
      tx_calm = 0;
      while (bin_stream.size() > 0) begin
         b   = bin_stream.pop_front();
         gap = pick_gap(tx_calm);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_bin_weight     <= b.weight;
         req_feature_id     <= b.feature_id;
         req_feature_usable <= b.usable;
         req_last_bin       <= b.last_bin;
         req_last_feature   <= b.last_feature;
         req_valid          <= 1'b1;
         @(posedge clock);
         while (!req_ready) begin
            stalled_cycles++;
            @(posedge clock);
         end
         split_board.note_bin(b);
         bins_sent++;
      end
      req_valid <= 1'b0;
   endtask

   // Main sequence
   initial begin
      split_board = new();

      // Search: extremes, stray last_feature, single bin, unusable, zero ties
      push_bin(W_MAX, 10'd3, 1'b0, 1'b0, 1'b1);
      push_bin(W_MIN, 10'd0, 1'b1, 1'b0, 1'b0);
      push_bin(W_MAX, 10'd1023, 1'b1, 1'b1, 1'b0);
      push_bin(W_MIN, 10'd0, 1'b1, 1'b1, 1'b0);
      push_bin(W_MAX, 10'd0, 1'b0, 1'b0, 1'b0);
      push_bin(W_MAX, 10'd0, 1'b1, 1'b0, 1'b0);
      push_bin(W_MAX, 10'd0, 1'b0, 1'b0, 1'b0);
      push_bin(W_MAX, 10'd5, 1'b0, 1'b1, 1'b0);
      push_bin('0, 10'd0, 1'b0, 1'b0, 1'b0);
      push_bin('0, 10'd0, 1'b0, 1'b0, 1'b0);
      push_bin('0, 10'd0, 1'b0, 1'b0, 1'b0);
      push_bin('0, 10'd7, 1'b1, 1'b1, 1'b0);
      push_bin(1, 10'd0, 1'b0, 1'b0, 1'b0);
      push_bin(-2, 10'd0, 1'b0, 1'b0, 1'b0);
      push_bin(1, 10'd512, 1'b1, 1'b1, 1'b1);
      // Search with no split at all
      push_bin(W_MAX, 10'd3, 1'b1, 1'b1, 1'b0);
      push_bin(W_MIN, 10'd0, 1'b1, 1'b0, 1'b0);
      push_bin(1, 10'd9, 1'b0, 1'b1, 1'b1);
      // First split taken even with a zero score
      push_bin(5, 10'd0, 1'b0, 1'b0, 1'b0);
      push_bin(5, 10'd11, 1'b1, 1'b1, 1'b1);
      // Right-heavy split, then a later feature that beats it
      push_bin(-7, 10'd0, 1'b0, 1'b0, 1'b0);
      push_bin(3, 10'd100, 1'b1, 1'b1, 1'b0);
      push_bin(W_MIN, 10'd0, 1'b0, 1'b0, 1'b0);
      push_bin(W_MIN, 10'd0, 1'b0, 1'b0, 1'b0);
      push_bin(W_MIN, 10'd200, 1'b1, 1'b1, 1'b1);

      // Store depth: exactly full, then past full with dropped bins
      add_feature(BIN_LIMIT, WGT_FULL, 10'd900, 1'b1, 1'b1);
      add_feature(BIN_LIMIT + 2, WGT_EXTREME, 10'd901, 1'b1, 1'b0);
      add_feature(2, WGT_SMALL, 10'd902, 1'b1, 1'b1);

      while (bin_stream.size() < BIN_TARGET)
         add_search();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      reset_done = 1'b1;

      send_bins();
      while (split_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      split_board.close_out();

      $display("Run covered %0d bins and %0d search results (%0d with a split, %0d overflowed).",
               bins_sent, split_board.results_seen, split_board.found_seen,
               split_board.overflow_results);
      $display("Output held off for %0d cycles; input back-pressured for %0d cycles in total.",
               HOLD_CYCLES, stalled_cycles);
      if (split_board.failures == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Result side: random stalls, check each transfer
   initial begin
      int unsigned      stall_left;
      int unsigned      rx_calm;
      split_result_type got;
      stall_left = 0;
      rx_calm    = 0;
      wait (reset_done);
      forever begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready  <= !rsp_hold;
            stall_left = pick_gap(rx_calm);
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.found        = rsp_found;
            got.feature      = rsp_best_feature;
            got.split_bin    = rsp_best_bin;
            got.left_heavier = rsp_left_heavier;
            got.score        = rsp_best_score;
            got.overflow     = rsp_bin_overflow;
            split_board.check_result(got);
         end
      end
   end

   // Long receiver hold-off mid-run so results back up and the input stalls
   initial begin
      wait (reset_done);
      while (bins_sent < HOLD_AFTER) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Watchdog
   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("Timeout with %0d results outstanding.", split_board.pending());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
